// ===== sv/stc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and helpers for the three-phase sinusoidal commutation block.
// Holds port widths, configuration register indexes and the cosine table builder.
// No dependencies.
package stc_pkg;

    localparam int ANGLE_BITS_DEF  = 16;
    localparam int COS_ENTRIES_DEF = 1024;

    localparam int ROT_W   = 16;
    localparam int AMP_W   = 16;
    localparam int DUTY_W  = 15;
    localparam int PP_W    = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_POLE_PAIRS  = CFG_IDX_W'(1);

    localparam logic [PP_W-1:0] POLE_PAIRS_RST = PP_W'(11);

    localparam int DUTY_MID  = 12800;
    localparam int DUTY_MAX  = 25600;
    localparam int ALIGN_AMP = 12800;

    // pi/2 in Q30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Pipeline depth of one phase lane, from folded angle to duty.
    localparam int LANE_LAT = 4;

    // Quotient by shift and subtract, for building constant tables at elaboration.
    function automatic longint unsigned udiv_const(input longint unsigned num,
                                                   input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        begin
            quo = '0;
            rem = '0;
            for (int b = 63; b >= 0; b--) begin
                rem = {rem[62:0], num[b]};
                if (rem >= den) begin
                    rem    = rem - den;
                    quo[b] = 1'b1;
                end
            end
            return quo;
        end
    endfunction

    // Cosine of x (Q30 radians, 0..pi/2) as Q1.15, by a ten-term Taylor series.
    function automatic logic [15:0] cos_q15(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned q;
        longint          sum;
        begin
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = longint'(term);
            for (int k = 1; k <= 9; k++) begin
                term = udiv_const((term * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
                if ((k % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            q = (longint'(sum) + 64'd16384) >> 15;
            if (q > 64'd32768) begin
                q = 64'd32768;
            end
            return q[15:0];
        end
    endfunction

endpackage

// ===== sv/stc_phase.sv =====
`timescale 1ns / 1ps
// One phase lane: quadrant fold, quarter-wave cosine lookup, amplitude multiply,
// offset and saturation to a duty value. Four register stages. Uses stc_pkg.
module stc_phase #(
    parameter int ANGLE_BITS        = stc_pkg::ANGLE_BITS_DEF,
    parameter int COS_TABLE_ENTRIES = stc_pkg::COS_ENTRIES_DEF
) (
    input  logic                               i_clk,
    input  logic [ANGLE_BITS-1:0]              i_angle,
    input  logic signed [stc_pkg::AMP_W-1:0]   i_amp,
    output logic [stc_pkg::DUTY_W-1:0]         o_duty
);
    import stc_pkg::*;

    localparam int IW  = $clog2(COS_TABLE_ENTRIES + 1);
    localparam int PW  = ANGLE_BITS - 1 + IW;
    localparam int QTR = 1 << (ANGLE_BITS - 2);
    localparam int QTR_HALF = 1 << (ANGLE_BITS - 3);
    localparam logic signed [34:0] DUTY_OFS = 35'(DUTY_MID * 65536 + 32768);

    // Quarter-wave table, folded to constants at elaboration.
    logic [15:0] w_tab [0:COS_TABLE_ENTRIES];

    for (genvar g = 0; g <= COS_TABLE_ENTRIES; g++) begin : g_tab
        localparam longint unsigned X =
            (64'(g) * HALF_PI_Q30) / 64'(COS_TABLE_ENTRIES);
        localparam logic [15:0] COS_VAL = cos_q15(X);
        assign w_tab[g] = COS_VAL;
    end

    // Stage 1: fold and index
    logic [1:0]              w_quad;
    logic [ANGLE_BITS-3:0]   w_rem;
    logic [ANGLE_BITS-2:0]   w_rr;
    logic [PW-1:0]           w_prod;
    logic [IW:0]             w_idx_full;
    logic [IW-1:0]           n_idx;
    logic                    n_neg;
    logic [IW-1:0]           r_idx;
    logic                    r_neg;
    logic signed [AMP_W-1:0] r_amp1;

    always_comb begin
        w_quad = i_angle[ANGLE_BITS-1:ANGLE_BITS-2];
        w_rem  = i_angle[ANGLE_BITS-3:0];
        // odd quadrants read the table mirrored
        if (w_quad[0]) begin
            w_rr = (ANGLE_BITS-1)'(QTR) - {1'b0, w_rem};
        end else begin
            w_rr = {1'b0, w_rem};
        end
        n_neg      = (w_quad == 2'd1) || (w_quad == 2'd2);
        w_prod     = PW'(w_rr) * PW'(COS_TABLE_ENTRIES) + PW'(QTR_HALF);
        w_idx_full = w_prod[PW-1:ANGLE_BITS-2];
        if (w_idx_full > (IW+1)'(COS_TABLE_ENTRIES)) begin
            n_idx = IW'(COS_TABLE_ENTRIES);
        end else begin
            n_idx = w_idx_full[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_neg  <= n_neg;
        r_amp1 <= i_amp;
    end

    // Stage 2: table read and sign
    logic signed [16:0]      n_cos;
    logic signed [16:0]      r_cos;
    logic signed [AMP_W-1:0] r_amp2;

    always_comb begin
        if (r_neg) begin
            n_cos = -$signed({1'b0, w_tab[r_idx]});
        end else begin
            n_cos = $signed({1'b0, w_tab[r_idx]});
        end
    end

    always_ff @(posedge i_clk) begin
        r_cos  <= n_cos;
        r_amp2 <= r_amp1;
    end

    // Stage 3: projection onto the amplitude
    logic signed [32:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= r_cos * r_amp2;
    end

    // Stage 4: offset to mid scale, round, saturate
    logic signed [34:0]       w_sum;
    logic signed [18:0]       w_shr;
    logic [DUTY_W-1:0]        n_duty;
    logic [DUTY_W-1:0]        r_duty;

    always_comb begin
        w_sum = 35'(r_prod) + DUTY_OFS;
        w_shr = w_sum[34:16];
        if (w_shr < 0) begin
            n_duty = '0;
        end else if (w_shr > 19'(DUTY_MAX)) begin
            n_duty = DUTY_W'(DUTY_MAX);
        end else begin
            n_duty = w_shr[DUTY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_duty <= n_duty;
    end

    assign o_duty = r_duty;

endmodule

// ===== sv/sinusoidal_three_phase_commutation.sv =====
`timescale 1ns / 1ps
// Three-phase sinusoidal commutation: rotor angle and amplitude in, three duties out.
// Each start transfer leaves the pipe as an o_valid strobe; throughput is one
// item per clock, so busy never rises. Depth is set by the angle offset, the pole-pair
// multiply, the phase offsets and the four stages of each lane (fold, table, multiply,
// offset). The receiver cannot stall. Synchronous active-low reset clears all in-flight
// valids and loads start_angle = 0, pole_pairs = 11. Uses stc_pkg and stc_phase.
module sinusoidal_three_phase_commutation #(
    parameter int ANGLE_BITS        = stc_pkg::ANGLE_BITS_DEF,
    parameter int COS_TABLE_ENTRIES = stc_pkg::COS_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic [stc_pkg::ROT_W-1:0]           i_rotor_angle,
    input  logic signed [stc_pkg::AMP_W-1:0]    i_amplitude,
    output logic                                o_valid,
    output logic [stc_pkg::DUTY_W-1:0]          o_duty_a,
    output logic [stc_pkg::DUTY_W-1:0]          o_duty_b,
    output logic [stc_pkg::DUTY_W-1:0]          o_duty_c,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [stc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [stc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import stc_pkg::*;

    localparam int AB  = ANGLE_BITS;
    localparam int EW  = (AB > ROT_W) ? AB : ROT_W;
    localparam int LAT = 3 + LANE_LAT;
    localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);
    localparam logic [AB-1:0] THIRD   = AB'(((64'd1 << AB) + 64'd1) / 64'd3);

    // Configuration registers
    logic [ROT_W-1:0] r_start_angle;
    logic [PP_W-1:0]  r_pole_pairs;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_angle <= '0;
            r_pole_pairs  <= POLE_PAIRS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_START_ANGLE: r_start_angle <= i_cfg_data;
                CFG_POLE_PAIRS:  r_pole_pairs  <= i_cfg_data[PP_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Valid bits follow the data down the pipe
    logic [LAT-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[LAT-2:0], start && !busy};
        end
    end

    assign o_valid = r_valid[LAT-1];

    // Stage 1: offset from the alignment angle
    logic [EW-1:0]      w_diff;
    logic [AB-1:0]      r_diff;
    logic               r_func;
    logic signed [AMP_W-1:0] r_amp1;

    assign w_diff = EW'(i_rotor_angle) - EW'(r_start_angle);

    always_ff @(posedge i_clk) begin
        r_diff <= w_diff[AB-1:0];
        r_func <= i_func;
        r_amp1 <= i_amplitude;
    end

    // Stage 2: electrical angle; align forces angle zero and half amplitude
    logic [AB+PP_W-1:0]      w_eprod;
    logic [AB-1:0]           n_elec;
    logic signed [AMP_W-1:0] n_amp2;
    logic [AB-1:0]           r_elec;
    logic signed [AMP_W-1:0] r_amp2;

    always_comb begin
        w_eprod = (AB+PP_W)'(r_diff) * (AB+PP_W)'(r_pole_pairs);
        if (r_func) begin
            n_elec = '0;
            n_amp2 = AMP_W'(ALIGN_AMP);
        end else begin
            n_elec = w_eprod[AB-1:0] + QUARTER;
            n_amp2 = r_amp1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elec <= n_elec;
        r_amp2 <= n_amp2;
    end

    // Stage 3: phase angles, B lags and C leads by a third turn
    logic [AB-1:0]           r_ang_a;
    logic [AB-1:0]           r_ang_b;
    logic [AB-1:0]           r_ang_c;
    logic signed [AMP_W-1:0] r_amp3;

    always_ff @(posedge i_clk) begin
        r_ang_a <= r_elec;
        r_ang_b <= r_elec - THIRD;
        r_ang_c <= r_elec + THIRD;
        r_amp3  <= r_amp2;
    end

    stc_phase #(
        .ANGLE_BITS        (ANGLE_BITS),
        .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES)
    ) u_phase_a (
        .i_clk   (i_clk),
        .i_angle (r_ang_a),
        .i_amp   (r_amp3),
        .o_duty  (o_duty_a)
    );

    stc_phase #(
        .ANGLE_BITS        (ANGLE_BITS),
        .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES)
    ) u_phase_b (
        .i_clk   (i_clk),
        .i_angle (r_ang_b),
        .i_amp   (r_amp3),
        .o_duty  (o_duty_b)
    );

    stc_phase #(
        .ANGLE_BITS        (ANGLE_BITS),
        .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES)
    ) u_phase_c (
        .i_clk   (i_clk),
        .i_angle (r_ang_c),
        .i_amp   (r_amp3),
        .o_duty  (o_duty_c)
    );

endmodule
